### sv/xte_pkg.sv
// Shared types, character codes and token spelling for the XML text escaper.
package xte_pkg;

  // Character codes
  localparam logic [7:0] ChrAmp   = 8'h26;
  localparam logic [7:0] ChrLt    = 8'h3C;
  localparam logic [7:0] ChrGt    = 8'h3E;
  localparam logic [7:0] ChrQuot  = 8'h22;
  localparam logic [7:0] ChrApos  = 8'h27;
  localparam logic [7:0] ChrHash  = 8'h23;
  localparam logic [7:0] ChrX     = 8'h78;
  localparam logic [7:0] ChrSemi  = 8'h3B;

  // Token spellings, right aligned, element 0 is the final character
  localparam logic [5:0][7:0] StrAmp  = {8'h0, "&amp;"};
  localparam logic [5:0][7:0] StrLt   = {16'h0, "&lt;"};
  localparam logic [5:0][7:0] StrGt   = {16'h0, "&gt;"};
  localparam logic [5:0][7:0] StrQuot = "&quot;";
  localparam logic [5:0][7:0] StrApos = "&apos;";
  localparam logic [5:0][7:0] StrHx   = {24'h0, "&#x"};

  // Output tokens that one input item expands into
  typedef enum logic [3:0] {
    TOK_NONE,
    TOK_BYTE,
    TOK_AMP,
    TOK_HASH,
    TOK_HX,
    TOK_LT,
    TOK_GT,
    TOK_QUOT,
    TOK_APOS
  } tok_e;

  // Held bytes in front of a possible character reference
  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_AMP,
    HELD_AMP_HASH
  } held_e;

  localparam int unsigned NumSlots = 3;

  // Command passed from the front end to the back end
  typedef struct packed {
    tok_e [NumSlots-1:0] tok;
    logic [7:0]          data;
    logic                fin;
  } cmd_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Number of characters in a token
  function automatic logic [2:0] tok_len(tok_e tok);
    logic [2:0] len;
    case (tok)
      TOK_BYTE: len = 3'd1;
      TOK_HASH: len = 3'd1;
      TOK_AMP:  len = 3'd5;
      TOK_HX:   len = 3'd3;
      TOK_LT:   len = 3'd4;
      TOK_GT:   len = 3'd4;
      TOK_QUOT: len = 3'd6;
      TOK_APOS: len = 3'd6;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  // Character at position idx of a token
  function automatic logic [7:0] tok_char(tok_e tok, logic [2:0] idx, logic [7:0] data);
    logic [2:0] sel;
    logic [7:0] chr;
    sel = 3'(tok_len(tok) - 3'd1 - idx);
    case (tok)
      TOK_BYTE: chr = data;
      TOK_HASH: chr = ChrHash;
      TOK_AMP:  chr = StrAmp[sel];
      TOK_HX:   chr = StrHx[sel];
      TOK_LT:   chr = StrLt[sel];
      TOK_GT:   chr = StrGt[sel];
      TOK_QUOT: chr = StrQuot[sel];
      TOK_APOS: chr = StrApos[sel];
      default:  chr = data;
    endcase
    return chr;
  endfunction

endpackage

### sv/xte_in_if.sv
// Input channel: raw text bytes with an end-of-string mark.
interface xte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

### sv/xte_out_if.sv
// Output channel: escaped text bytes with run and string end marks.
interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_done,
                  output ready);
endinterface

### sv/xte_front.sv
// Front end: track reference mode and held bytes, classify each byte into tokens.
module xte_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             string_end_i,
  output logic             push_o,
  output xte_pkg::cmd_t    cmd_o
);
  import xte_pkg::*;

  logic  in_ref_q, in_ref_d;
  held_e held_q, held_d;
  tok_e  plain_tok;
  tok_e  t0, t1, t2;

  // Classify a byte in normal mode with nothing held
  always_comb begin
    case (in_byte_i)
      ChrAmp:  plain_tok = string_end_i ? TOK_AMP : TOK_NONE;
      ChrLt:   plain_tok = TOK_LT;
      ChrGt:   plain_tok = TOK_GT;
      ChrQuot: plain_tok = TOK_QUOT;
      ChrApos: plain_tok = TOK_APOS;
      default: plain_tok = TOK_BYTE;
    endcase
  end

  // Build the token list and the next mode
  always_comb begin
    t0       = TOK_NONE;
    t1       = TOK_NONE;
    t2       = TOK_NONE;
    in_ref_d = in_ref_q;
    held_d   = held_q;
    if (in_ref_q) begin
      t0 = TOK_BYTE;
      if (in_byte_i == ChrSemi) in_ref_d = 1'b0;
    end else begin
      case (held_q)
        HELD_AMP: begin
          if (in_byte_i == ChrHash) begin
            held_d = HELD_AMP_HASH;
            if (string_end_i) begin
              t0 = TOK_AMP;
              t1 = TOK_HASH;
            end
          end else begin
            held_d = (in_byte_i == ChrAmp) ? HELD_AMP : HELD_NONE;
            t0     = TOK_AMP;
            t1     = plain_tok;
          end
        end
        HELD_AMP_HASH: begin
          if (in_byte_i == ChrX) begin
            held_d   = HELD_NONE;
            in_ref_d = 1'b1;
            t0       = TOK_HX;
          end else begin
            held_d = (in_byte_i == ChrAmp) ? HELD_AMP : HELD_NONE;
            t0     = TOK_AMP;
            t1     = TOK_HASH;
            t2     = plain_tok;
          end
        end
        default: begin
          held_d = (in_byte_i == ChrAmp) ? HELD_AMP : HELD_NONE;
          t0     = plain_tok;
        end
      endcase
    end
    // End of string drops all mode state
    if (string_end_i) begin
      held_d   = HELD_NONE;
      in_ref_d = 1'b0;
    end
  end

  assign cmd_o.tok[0] = t0;
  assign cmd_o.tok[1] = t1;
  assign cmd_o.tok[2] = t2;
  assign cmd_o.data   = in_byte_i;
  assign cmd_o.fin    = string_end_i;
  assign push_o       = accept_i && (t0 != TOK_NONE);

  // Advance mode on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ref_q <= 1'b0;
      held_q   <= HELD_NONE;
    end else if (accept_i) begin
      in_ref_q <= in_ref_d;
      held_q   <= held_d;
    end
  end

endmodule

### sv/xte_fifo.sv
// Two-entry command queue between the front and back ends.
module xte_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xte_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output xte_pkg::cmd_t    cmd_o,
  output xte_pkg::qstat_t  stat_o
);
  import xte_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign cmd_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/xte_back.sv
// Back end: spell out the tokens of the head command, one byte per cycle while the output is ready.
module xte_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  xte_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  xte_out_if.source        out_o
);
  import xte_pkg::*;

  logic [1:0] slot_q;
  logic [2:0] pos_q;
  tok_e       cur_tok, nxt_tok;
  logic       last_chr, last_tok, xfer;

  // Select current and following token
  always_comb begin
    case (slot_q)
      2'd0: begin
        cur_tok = cmd_i.tok[0];
        nxt_tok = cmd_i.tok[1];
      end
      2'd1: begin
        cur_tok = cmd_i.tok[1];
        nxt_tok = cmd_i.tok[2];
      end
      default: begin
        cur_tok = cmd_i.tok[2];
        nxt_tok = TOK_NONE;
      end
    endcase
  end

  assign last_chr = (pos_q == 3'(tok_len(cur_tok) - 3'd1));
  assign last_tok = (nxt_tok == TOK_NONE);
  assign xfer     = avail_i && out_o.ready;
  assign pop_o    = xfer && last_chr && last_tok;

  assign out_o.valid     = avail_i;
  assign out_o.out_byte  = tok_char(cur_tok, pos_q, cmd_i.data);
  assign out_o.run_last  = last_chr && last_tok;
  assign out_o.text_done = last_chr && last_tok && cmd_i.fin;

  // Step through characters and tokens on each output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 2'd0;
      pos_q  <= 3'd0;
    end else if (xfer) begin
      if (last_chr && last_tok) begin
        slot_q <= 2'd0;
        pos_q  <= 3'd0;
      end else if (last_chr) begin
        slot_q <= slot_q + 2'd1;
        pos_q  <= 3'd0;
      end else begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

endmodule

### sv/xml_text_escaper.sv
// XML text escaper top level: front classifier, command queue, back-end speller.
// Latency: with the queue empty, the first byte of an item's output is offered the cycle
// after its transfer; a held ampersand waits for the byte that decides it.
// Throughput: one input byte per cycle; an item that expands to N bytes (up to 12)
// holds the back end until all N are sent, and input stalls while the two-entry queue is full.
// Reset (rst_ni low, asynchronous) clears reference mode, held bytes and the queue.
module xml_text_escaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  xte_in_if.sink     in_i,
  xte_out_if.source  out_o
);
  import xte_pkg::*;

  logic   accept, push, pop;
  cmd_t   push_cmd, head_cmd;
  qstat_t qstat;

  assign in_i.ready = !qstat.full;
  assign accept     = in_i.valid && in_i.ready;

  xte_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_i.in_byte),
    .string_end_i (in_i.string_end),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  xte_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (qstat)
  );

  xte_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!qstat.empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.text_done) |-> out_o.run_last)
    else $error("text_done without run_last");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full))
    else $error("queue overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && qstat.empty))
    else $error("queue underflow");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> !qstat.full)
    else $error("queue still full after pop");
`endif

endmodule
